### hw/rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants of the bounded deque: depth, word and count
// widths, operation codes, and the structs passed along the cell chain.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int MAX_DEPTH = 1024;
    localparam int WORD_W    = 32;
    localparam int CAP_W     = 11;
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
    localparam int CAP_RESET = 1024;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [CNT_W-1:0]         t_count;
    typedef logic [CAP_W-1:0]         t_cap;

    typedef enum logic [1:0] {
        FUNC_INS_FRONT = 2'd0,
        FUNC_INS_REAR  = 2'd1,
        FUNC_DEL_FRONT = 2'd2,
        FUNC_DEL_REAR  = 2'd3
    } t_func;

    // what one cell shows its neighbors
    typedef struct packed {
        logic  valid;
        t_word a;     // entry counted from the front
        t_word b;     // entry counted from the rear
    } t_link;

    // operation broadcast to every cell, already qualified by success
    typedef struct packed {
        logic  ins_front;
        logic  ins_rear;
        logic  del_front;
        logic  del_rear;
        t_word word;
    } t_cmd;

endpackage

### hw/rtl/bdq_cell.sv
// ----------------------------------------------------------------------------
// bdq_cell
// One slot of the deque chain. Holds an occupancy bit, the entry at this
// distance from the front and the entry at this distance from the rear.
// ----------------------------------------------------------------------------
module bdq_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bdq_pkg::t_cmd  i_cmd,
    input  bdq_pkg::t_link i_left,
    input  bdq_pkg::t_link i_right,
    output bdq_pkg::t_link o_link
);

    logic          r_valid;
    logic          n_valid;
    bdq_pkg::t_word r_a;
    bdq_pkg::t_word n_a;
    bdq_pkg::t_word r_b;
    bdq_pkg::t_word n_b;
    logic          w_first_empty;

    // occupancy is a thermometer, so the first free slot is known locally
    assign w_first_empty = !r_valid && i_left.valid;

    always_comb begin
        n_valid = r_valid;
        n_a     = r_a;
        n_b     = r_b;
        if (i_cmd.ins_front) begin
            n_valid = i_left.valid;
            n_a     = i_left.a;
            if (w_first_empty) begin
                n_b = i_cmd.word;
            end
        end else if (i_cmd.ins_rear) begin
            n_valid = i_left.valid;
            n_b     = i_left.b;
            if (w_first_empty) begin
                n_a = i_cmd.word;
            end
        end else if (i_cmd.del_front) begin
            n_valid = i_right.valid;
            n_a     = i_right.a;
        end else if (i_cmd.del_rear) begin
            n_valid = i_right.valid;
            n_b     = i_right.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
    end

    assign o_link.valid = r_valid;
    assign o_link.a     = r_a;
    assign o_link.b     = r_b;

endmodule

### hw/rtl/bounded_double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_top
// Bounded deque of 32-bit signed words with a programmable capacity.
// ----------------------------------------------------------------------------
// The deque is a row of MAX_DEPTH cells. Each cell keeps the entry at its
// distance from the front and, in a second word, the entry at its distance
// from the rear, so both ends always sit in cell 0 and every operation is a
// one-step shift of one word column, inserts adding a write into the first
// free cell. One item is taken per clock cycle; its result is registered
// and shown the cycle after acceptance, and a new item is taken whenever
// the result register is empty or being drained. Capacity values above
// MAX_DEPTH act as MAX_DEPTH, zero refuses every insert, and a capacity
// below the current occupancy refuses inserts only. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [10:0]           i_cfg_capacity,
    // operation items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_func,
    input  logic signed [31:0]    i_value,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_success,
    output logic signed [31:0]    o_front_value,
    output logic signed [31:0]    o_rear_value,
    output logic                  o_is_empty,
    output logic                  o_is_full,
    output logic [10:0]           o_occupancy
);

    bdq_pkg::t_cap   r_capacity;
    bdq_pkg::t_count r_count;
    bdq_pkg::t_count n_count;
    bdq_pkg::t_count w_eff_cap;
    logic            w_full;
    logic            w_empty;
    logic            w_in_fire;
    logic            w_ok;
    bdq_pkg::t_cmd   w_cmd;
    bdq_pkg::t_link  w_link [bdq_pkg::MAX_DEPTH];
    bdq_pkg::t_link  w_head_in;
    bdq_pkg::t_word  w_front;
    bdq_pkg::t_word  w_rear;

    logic            r_out_valid;
    logic            r_success;
    bdq_pkg::t_word  r_front;
    bdq_pkg::t_word  r_rear;
    logic            r_is_empty;
    logic            r_is_full;
    bdq_pkg::t_count r_occupancy;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_fire   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= bdq_pkg::t_cap'(bdq_pkg::CAP_RESET);
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_capacity;
        end
    end

    assign w_eff_cap = (int'(r_capacity) > bdq_pkg::MAX_DEPTH)
                       ? bdq_pkg::t_count'(bdq_pkg::MAX_DEPTH)
                       : bdq_pkg::t_count'(r_capacity);
    assign w_full  = r_count >= w_eff_cap;
    assign w_empty = r_count == '0;

    always_comb begin
        w_ok = 1'b0;
        case (bdq_pkg::t_func'(i_func))
            bdq_pkg::FUNC_INS_FRONT: w_ok = !w_full;
            bdq_pkg::FUNC_INS_REAR:  w_ok = !w_full;
            bdq_pkg::FUNC_DEL_FRONT: w_ok = !w_empty;
            bdq_pkg::FUNC_DEL_REAR:  w_ok = !w_empty;
            default:                 w_ok = 1'b0;
        endcase
    end

    assign w_cmd.ins_front = w_in_fire && w_ok && (i_func == bdq_pkg::FUNC_INS_FRONT);
    assign w_cmd.ins_rear  = w_in_fire && w_ok && (i_func == bdq_pkg::FUNC_INS_REAR);
    assign w_cmd.del_front = w_in_fire && w_ok && (i_func == bdq_pkg::FUNC_DEL_FRONT);
    assign w_cmd.del_rear  = w_in_fire && w_ok && (i_func == bdq_pkg::FUNC_DEL_REAR);
    assign w_cmd.word      = i_value;

    always_comb begin
        n_count = r_count;
        if (w_cmd.ins_front || w_cmd.ins_rear) begin
            n_count = r_count + bdq_pkg::t_count'(1);
        end else if (w_cmd.del_front || w_cmd.del_rear) begin
            n_count = r_count - bdq_pkg::t_count'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // the slot ahead of cell 0 always looks occupied and holds the new word
    assign w_head_in.valid = 1'b1;
    assign w_head_in.a     = i_value;
    assign w_head_in.b     = i_value;

    for (genvar gi = 0; gi < bdq_pkg::MAX_DEPTH; gi++) begin : g_cell
        bdq_pkg::t_link w_left;
        bdq_pkg::t_link w_right;
        if (gi == 0) begin : g_first
            assign w_left = w_head_in;
        end else begin : g_mid_l
            assign w_left = w_link[gi-1];
        end
        if (gi == bdq_pkg::MAX_DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_link[gi+1];
        end
        bdq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[gi])
        );
    end

    // ends after the operation, taken from the first two cells
    always_comb begin
        w_front = w_link[0].a;
        w_rear  = w_link[0].b;
        if (w_cmd.ins_front) begin
            w_front = i_value;
            if (w_empty) begin
                w_rear = i_value;
            end
        end else if (w_cmd.ins_rear) begin
            w_rear = i_value;
            if (w_empty) begin
                w_front = i_value;
            end
        end else if (w_cmd.del_front) begin
            w_front = w_link[1].a;
        end else if (w_cmd.del_rear) begin
            w_rear = w_link[1].b;
        end
        if (n_count == '0) begin
            w_front = '1;
            w_rear  = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_success   <= w_ok;
            r_front     <= w_front;
            r_rear      <= w_rear;
            r_is_empty  <= n_count == '0;
            r_is_full   <= n_count >= w_eff_cap;
            r_occupancy <= n_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_success     = r_success;
    assign o_front_value = r_front;
    assign o_rear_value  = r_rear;
    assign o_is_empty    = r_is_empty;
    assign o_is_full     = r_is_full;
    assign o_occupancy   = 11'(r_occupancy);

endmodule

### hw/rtl/bdq_checker.sv
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks of the bounded deque, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input logic [10:0]         i_cfg_capacity,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic [1:0]          i_func,
    input logic signed [31:0]  i_value,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic                o_success,
    input logic signed [31:0]  o_front_value,
    input logic signed [31:0]  o_rear_value,
    input logic                o_is_empty,
    input logic                o_is_full,
    input logic [10:0]         o_occupancy
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    // input is only stalled behind a pending result
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending result");

    // empty flag, count and end words agree
    a_empty_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_occupancy == 11'd0)) &&
                        (!o_is_empty || (o_front_value == -32'sd1 &&
                                         o_rear_value == -32'sd1)))
        else $error("empty flag inconsistent with result");

    // a single entry is both front and rear
    a_single_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_occupancy == 11'd1 |-> o_front_value == o_rear_value)
        else $error("front and rear differ with one entry");

    // a refused insert only happens when full
    a_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_success && !o_is_empty |-> o_is_full)
        else $error("operation refused on a non-full, non-empty deque");

endmodule

bind bounded_double_ended_queue_top bdq_checker u_bdq_checker (.*);

### test/bounded_double_ended_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_top_tb
// Drives front/rear insert and delete items into the bounded deque, keeps a
// ring-buffer copy of its contents, and checks every result field by field.
// Capacity is changed between phases: zero, small, lowered below occupancy,
// and saturated, with a long phase that fills the whole store.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_top_tb;

    localparam int PTR_W        = $clog2(bdq_pkg::MAX_DEPTH);
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PRINT_LIMIT  = 30;

    typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC, RX_LONG} t_rx_mode;

    typedef struct packed {
        logic            success;
        bdq_pkg::t_word  front_word;
        bdq_pkg::t_word  rear_word;
        logic            empty;
        logic            full;
        bdq_pkg::t_count occupancy;
    } t_snapshot;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [10:0]        i_cfg_capacity = '0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_func         = bdq_pkg::FUNC_INS_FRONT;
    logic signed [31:0] i_value        = '0;
    logic               o_out_valid;
    logic               i_out_ready    = 1'b0;
    logic               o_success;
    logic signed [31:0] o_front_value;
    logic signed [31:0] o_rear_value;
    logic               o_is_empty;
    logic               o_is_full;
    logic [10:0]        o_occupancy;

    // shadow copy of the deque
    bdq_pkg::t_word    shadow_mem [bdq_pkg::MAX_DEPTH];
    logic [PTR_W-1:0]  shadow_head;
    logic [PTR_W-1:0]  shadow_tail;
    bdq_pkg::t_count   shadow_count;
    bdq_pkg::t_cap     shadow_cap;

    t_snapshot         pending_snapshots [$];

    int       mismatch_count  = 0;
    int       ops_sent        = 0;
    int       results_checked = 0;
    int       refused_count   = 0;
    int       full_seen       = 0;
    int       peak_occupancy  = 0;
    int       cap_writes      = 0;
    int       quiet_cycles    = 0;
    int       burst_left      = 0;
    int       stall_tick      = 0;
    t_rx_mode stall_mode      = RX_STEADY;

    bounded_double_ended_queue_top u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [PTR_W-1:0] slot_after(input logic [PTR_W-1:0] p);
        return (p == bdq_pkg::MAX_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] slot_before(input logic [PTR_W-1:0] p);
        return (p == 0) ? PTR_W'(bdq_pkg::MAX_DEPTH - 1) : p - 1'b1;
    endfunction

    // applies one operation to the shadow deque and returns what it shows after
    function automatic t_snapshot apply_deque_op(input bdq_pkg::t_func op,
                                                 input bdq_pkg::t_word word);
        t_snapshot snap;
        int        limit;
        logic      full_before;
        logic      empty_before;
        limit        = (int'(shadow_cap) > bdq_pkg::MAX_DEPTH) ? bdq_pkg::MAX_DEPTH
                                                               : int'(shadow_cap);
        full_before  = (int'(shadow_count) >= limit);
        empty_before = (shadow_count == 0);
        snap.success = 1'b0;
        case (op)
            bdq_pkg::FUNC_INS_FRONT: begin
                if (!full_before) begin
                    shadow_head             = slot_before(shadow_head);
                    shadow_mem[shadow_head] = word;
                    shadow_count            = shadow_count + 1'b1;
                    snap.success            = 1'b1;
                end
            end
            bdq_pkg::FUNC_INS_REAR: begin
                if (!full_before) begin
                    shadow_mem[shadow_tail] = word;
                    shadow_tail             = slot_after(shadow_tail);
                    shadow_count            = shadow_count + 1'b1;
                    snap.success            = 1'b1;
                end
            end
            bdq_pkg::FUNC_DEL_FRONT: begin
                if (!empty_before) begin
                    shadow_head  = slot_after(shadow_head);
                    shadow_count = shadow_count - 1'b1;
                    snap.success = 1'b1;
                end
            end
            default: begin
                if (!empty_before) begin
                    shadow_tail  = slot_before(shadow_tail);
                    shadow_count = shadow_count - 1'b1;
                    snap.success = 1'b1;
                end
            end
        endcase
        if (shadow_count != 0) begin
            snap.front_word = shadow_mem[shadow_head];
            snap.rear_word  = shadow_mem[slot_before(shadow_tail)];
        end else begin
            snap.front_word = '1;
            snap.rear_word  = '1;
        end
        snap.empty     = (shadow_count == 0);
        snap.full      = (int'(shadow_count) >= limit);
        snap.occupancy = shadow_count;
        return snap;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] result %0d %s: got %0h expected %0h",
                     $time, results_checked, what, got, want);
        mismatch_count++;
    endtask

    // predicts on every accepted item, checks every accepted result
    always @(posedge i_clk) begin : result_check
        t_snapshot want;
        if (!i_rst_n) begin
            shadow_head  = '0;
            shadow_tail  = '0;
            shadow_count = '0;
            shadow_cap   = bdq_pkg::t_cap'(bdq_pkg::CAP_RESET);
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                shadow_cap = i_cfg_capacity;
                cap_writes++;
            end
            if (i_in_valid && o_in_ready) begin
                pending_snapshots.push_back(
                    apply_deque_op(bdq_pkg::t_func'(i_func), i_value));
                ops_sent++;
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_snapshots.size() == 0) begin
                    report_mismatch("unexpected result", 32'(o_occupancy), '0);
                end else begin
                    want = pending_snapshots.pop_front();
                    if (o_success !== want.success)
                        report_mismatch("success", 32'(o_success), 32'(want.success));
                    if (o_front_value !== want.front_word)
                        report_mismatch("front_value", o_front_value, want.front_word);
                    if (o_rear_value !== want.rear_word)
                        report_mismatch("rear_value", o_rear_value, want.rear_word);
                    if (o_is_empty !== want.empty)
                        report_mismatch("is_empty", 32'(o_is_empty), 32'(want.empty));
                    if (o_is_full !== want.full)
                        report_mismatch("is_full", 32'(o_is_full), 32'(want.full));
                    if (o_occupancy !== want.occupancy)
                        report_mismatch("occupancy", 32'(o_occupancy), 32'(want.occupancy));
                    if (!want.success) refused_count++;
                    if (want.full) full_seen++;
                    if (int'(want.occupancy) > peak_occupancy)
                        peak_occupancy = int'(want.occupancy);
                end
                results_checked++;
            end
        end
    end

    // result stalls: mode picked at random on a free-running tick counter
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 64 == 0)
            stall_mode <= t_rx_mode'($urandom_range(0, 3));
        case (stall_mode)
            RX_STEADY:   i_out_ready <= 1'b1;
            RX_RANDOM:   i_out_ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: i_out_ready <= ((stall_tick % 7) < 4);
            default:     i_out_ready <= ((stall_tick % 32) >= 12);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_op(input bdq_pkg::t_func op, input bdq_pkg::t_word word);
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_func     <= op;
        i_value    <= word;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = $urandom_range(1, 5);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(0, 20);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_snapshots.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input bdq_pkg::t_cap cap);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_cfg_capacity <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic bdq_pkg::t_word pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random_ops(input int count, input int insert_pct);
        bdq_pkg::t_func op;
        repeat (count) begin
            if ($urandom_range(0, 99) < insert_pct)
                op = $urandom_range(0, 1) ? bdq_pkg::FUNC_INS_REAR
                                          : bdq_pkg::FUNC_INS_FRONT;
            else
                op = $urandom_range(0, 1) ? bdq_pkg::FUNC_DEL_REAR
                                          : bdq_pkg::FUNC_DEL_FRONT;
            send_op(op, pick_word());
        end
    endtask

    task automatic test_empty_after_reset();
        send_op(bdq_pkg::FUNC_DEL_FRONT, 32'sh1234_5678);
        send_op(bdq_pkg::FUNC_DEL_REAR, -32'sd1);
    endtask

    // head wraps below slot zero on the first front insert
    task automatic test_both_ends();
        write_capacity(bdq_pkg::t_cap'(2));
        send_op(bdq_pkg::FUNC_INS_FRONT, 32'sh7fff_ffff);
        send_op(bdq_pkg::FUNC_INS_REAR, 32'sh8000_0000);
        send_op(bdq_pkg::FUNC_INS_REAR, -32'sd1);
        send_op(bdq_pkg::FUNC_INS_FRONT, '0);
        send_op(bdq_pkg::FUNC_DEL_FRONT, '0);
        send_op(bdq_pkg::FUNC_DEL_REAR, '0);
        send_op(bdq_pkg::FUNC_DEL_REAR, '0);
        send_op(bdq_pkg::FUNC_INS_REAR, '0);
        send_op(bdq_pkg::FUNC_DEL_FRONT, -32'sd1);
    endtask

    task automatic test_zero_capacity();
        write_capacity('0);
        send_op(bdq_pkg::FUNC_INS_FRONT, 32'sh0000_0001);
        send_op(bdq_pkg::FUNC_INS_REAR, 32'sh8000_0000);
        send_op(bdq_pkg::FUNC_DEL_FRONT, '0);
        send_op(bdq_pkg::FUNC_DEL_REAR, '0);
    endtask

    // inserts refused, deletes still allowed while over the limit
    task automatic test_capacity_below_occupancy();
        write_capacity(bdq_pkg::t_cap'(3));
        send_op(bdq_pkg::FUNC_INS_REAR, 32'sh5555_aaaa);
        send_op(bdq_pkg::FUNC_INS_FRONT, 32'shaaaa_5555);
        send_op(bdq_pkg::FUNC_INS_REAR, 32'sh0f0f_f0f0);
        write_capacity(bdq_pkg::t_cap'(1));
        send_op(bdq_pkg::FUNC_INS_REAR, 32'sh0000_0042);
        send_op(bdq_pkg::FUNC_DEL_FRONT, '0);
        write_capacity('0);
        send_op(bdq_pkg::FUNC_INS_FRONT, 32'sh0000_0043);
        send_op(bdq_pkg::FUNC_DEL_REAR, '0);
        send_op(bdq_pkg::FUNC_DEL_REAR, '0);
        send_op(bdq_pkg::FUNC_DEL_FRONT, '0);
    endtask

    task automatic test_small_capacities();
        for (int cap = 1; cap <= 3; cap++) begin
            write_capacity(bdq_pkg::t_cap'(cap));
            run_random_ops(40, 50);
        end
    endtask

    task automatic test_random_capacities();
        repeat (2) begin
            write_capacity(bdq_pkg::t_cap'($urandom_range(4, 40)));
            run_random_ops(60, 65);
            run_random_ops(40, 35);
        end
    endtask

    // all-ones capacity saturates to the full store; fill it, then shrink
    task automatic test_fill_to_depth();
        write_capacity('1);
        run_random_ops(1200, 95);
        write_capacity(bdq_pkg::t_cap'(5));
        run_random_ops(40, 50);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_after_reset();
        test_both_ends();
        test_zero_capacity();
        test_capacity_below_occupancy();
        test_small_capacities();
        test_random_capacities();
        test_fill_to_depth();

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("%0d items sent, %0d results checked, %0d refused, over %0d capacity settings",
                 ops_sent, results_checked, refused_count, cap_writes);
        $display("deepest occupancy %0d of %0d slots, full flag seen on %0d results",
                 peak_occupancy, bdq_pkg::MAX_DEPTH, full_seen);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
